/* sv/cota_pkg.sv */
package cota_pkg;

    // accumulator width of the running hash
    localparam int ACC_WIDTH = 64;
    localparam int INDEX_WIDTH = 32;
    localparam int BITS_WIDTH = 6;

    // shift amounts of the per-byte mix and the final mix
    localparam int MIX_SHL = 10;
    localparam int MIX_SHR = 6;
    localparam int FIN_SHL_A = 3;
    localparam int FIN_SHR = 11;
    localparam int FIN_SHL_B = 15;

    localparam logic [BITS_WIDTH-1:0] INDEX_BITS_RESET = 6'd10;
    localparam logic [7:0] CHAR_END = 8'h00;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef logic [ACC_WIDTH-1:0] acc_t;
    typedef logic [INDEX_WIDTH-1:0] index_t;
    typedef logic [BITS_WIDTH-1:0] bits_t;

    // ascii upper case to lower case, all other bytes unchanged
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

    // one add, shift-add, xor step per byte
    function automatic acc_t mix_byte(input acc_t acc, input logic [7:0] b);
        acc_t h;
        h = acc + acc_t'(b);
        h = h + (h << MIX_SHL);
        h = h ^ (h >> MIX_SHR);
        return h;
    endfunction

    // final avalanche on the terminator
    function automatic acc_t finalize(input acc_t acc);
        acc_t h;
        h = acc + (acc << FIN_SHL_A);
        h = h ^ (h >> FIN_SHR);
        h = h + (h << FIN_SHL_B);
        return h;
    endfunction

    // low-bit mask, widths above the index width saturate to all ones
    function automatic index_t index_mask(input bits_t bits);
        index_t m;
        for (int i = 0; i < INDEX_WIDTH; i++)
        begin
            m[i] = (bits_t'(i) < bits);
        end
        return m;
    endfunction

endpackage

/* sv/caseless_one_at_a_time_hash.sv */
// Result: the hash_index of a terminator item is registered in hash_index_reg
//   after the terminator has been held in byte_reg; a held earlier result can delay it.
// Throughput: one byte item per cycle while no terminator is waiting; a terminator
//   waits only while an earlier result is still held by the downstream side.
// Reset (rst_n low, asynchronous): accumulator cleared, no item held,
//   index_bits back to 10.
module caseless_one_at_a_time_hash
    import cota_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output index_t     hash_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  bits_t      index_bits
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    index_t     hash_index_reg;
    index_t     hash_index_next;
    acc_t       acc_reg;
    acc_t       acc_next;
    acc_t       fin_acc;
    index_t     mask_reg;
    index_t     mask_next;

    logic       is_end;
    logic       advance;
    logic       in_take;
    logic       out_take;

    // stage control
    assign is_end   = (byte_reg == CHAR_END);
    assign out_take = out_valid_reg && out_ready;
    assign advance  = in_valid_reg && (!is_end || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign in_valid_next = in_take || (in_valid_reg && !advance);

    // final mix of the running hash
    assign fin_acc = finalize(acc_reg);

    // accumulator update and result formation
    always_comb
    begin
        acc_next        = acc_reg;
        hash_index_next = hash_index_reg;
        out_valid_next  = out_valid_reg && !out_take;
        if (advance)
        begin
            if (is_end)
            begin
                hash_index_next = fin_acc[INDEX_WIDTH-1:0] & mask_reg;
                out_valid_next  = 1'b1;
                acc_next        = '0;
            end
            else
            begin
                acc_next = mix_byte(acc_reg, fold_case(byte_reg));
            end
        end
    end

    // configuration, mask kept ready for the terminator
    assign cfg_ready = 1'b1;
    assign mask_next = (cfg_valid && cfg_ready) ? index_mask(index_bits) : mask_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            mask_reg      <= index_mask(INDEX_BITS_RESET);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            mask_reg      <= mask_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= char_byte;
        end
        hash_index_reg <= hash_index_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_index = hash_index_reg;

endmodule

/* sv/cota_checker.sv */
module cota_checker
    import cota_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_byte,
    input logic       out_valid,
    input logic       out_ready,
    input index_t     hash_index,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_index))
        else $error("result changed while stalled");

    // input only stalls behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with output free");

    // a new result comes only from a terminator item taken at the input
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && char_byte == CHAR_END, 2))
        else $error("result without terminator");

    // configuration writes never wait
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind caseless_one_at_a_time_hash cota_checker u_cota_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_byte  (char_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_index (hash_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
